### rtl/bdqi_pkg.sv
// ----------------------------------------------------------------------------
// bdqi_pkg: shared types and helpers for the bounded deque with insert
// Holds the request action codes, the cell control bundle, the controller
// states and the sizing helpers of the readout tree.
// ----------------------------------------------------------------------------
package bdqi_pkg;

   // Action codes carried by a request.
   typedef enum logic [2:0] {
      ACT_PUSH_BACK  = 3'd0,
      ACT_POP_BACK   = 3'd1,
      ACT_PUSH_FRONT = 3'd2,
      ACT_POP_FRONT  = 3'd3,
      ACT_INSERT_AT  = 3'd4,
      ACT_EXTRACT_AT = 3'd5
   } action_type;

   // What every cell does with its slot on an accepted request.
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_OPEN,
      CELL_CLOSE
   } cell_op_type;

   // Control bundle broadcast from the controller to the cell row.
   typedef struct packed {
      logic        load;
      cell_op_type op;
      logic        pick_en;
   } cell_ctrl_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WAIT,
      ST_SEND
   } state_type;

   // Fan-in of one node of the readout tree.
   localparam int TREE_RADIX = 8;

   // Number of registered levels needed to reduce n leaves to one root.
   function automatic int tree_levels(input int n);
      int span;
      int lv;
      span = 1;
      lv   = 0;
      while (span < n) begin
         span = span * TREE_RADIX;
         lv++;
      end
      if (lv < 1) begin
         lv = 1;
      end
      return lv;
   endfunction

   // Offset of tree level k (k counted from 1) in the flat node store.
   function automatic int tree_base(input int levels, input int k);
      int base;
      int m;
      base = 0;
      for (m = 1; m < k; m++) begin
         base = base + TREE_RADIX ** (levels - m);
      end
      return base;
   endfunction

endpackage

### rtl/bdqi_cell.sv
// ----------------------------------------------------------------------------
// bdqi_cell: one slot of the ordered store
// Holds one element and, on command, loads a new element, takes its left
// neighbor's element (opening a gap) or its right neighbor's (closing one).
// It also captures its element for the readout tree when it is picked.
// ----------------------------------------------------------------------------
module bdqi_cell
   import bdqi_pkg::*;
#(
   parameter int W   = 32,
   parameter int CW  = 7,
   parameter int IDX = 0
) (
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  logic [CW-1:0] at,
   input  logic [CW-1:0] count,
   input  logic [CW-1:0] pick_idx,
   input  logic [W-1:0]  elem,
   input  logic [W-1:0]  left_in,
   input  logic [W-1:0]  right_in,
   output logic [W-1:0]  slot_out,
   output logic [W-1:0]  pick_out
);

   localparam logic [CW-1:0] MY_IDX   = CW'(IDX);
   localparam logic [CW-1:0] NEXT_IDX = CW'(IDX + 1);

   logic [W-1:0] slot_ff;
   logic [W-1:0] slot_in;
   logic [W-1:0] pick_ff;
   logic [W-1:0] pick_in;

   // Slot update and pick capture for one accepted request.
   always_comb begin
      slot_in = slot_ff;
      pick_in = pick_ff;
      if (ctrl.load) begin
         pick_in = (ctrl.pick_en && (pick_idx == MY_IDX)) ? slot_ff : '0;
         case (ctrl.op)
            CELL_OPEN: begin
               if (MY_IDX == at) begin
                  slot_in = elem;
               end else if ((MY_IDX > at) && (MY_IDX <= count)) begin
                  slot_in = left_in;
               end
            end
            CELL_CLOSE: begin
               if ((MY_IDX >= at) && (NEXT_IDX < count)) begin
                  slot_in = right_in;
               end
            end
            default: begin
               slot_in = slot_ff;
            end
         endcase
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      pick_ff <= pick_in;
   end

   assign slot_out = slot_ff;
   assign pick_out = pick_ff;

endmodule

### rtl/bdqi_pick_tree.sv
// ----------------------------------------------------------------------------
// bdqi_pick_tree: registered OR tree for the element readout
// At most one cell presents a nonzero pick, so an OR reduction selects it.
// Each level combines eight nodes and is registered.
// ----------------------------------------------------------------------------
module bdqi_pick_tree
   import bdqi_pkg::*;
#(
   parameter int N = 64,
   parameter int W = 32
) (
   input  logic         clock,
   input  logic [W-1:0] leaf_in [N],
   output logic [W-1:0] root_out
);

   localparam int LEVELS = tree_levels(N);
   localparam int LEAVES = TREE_RADIX ** LEVELS;
   localparam int TOTAL  = tree_base(LEVELS, LEVELS + 1);

   logic [W-1:0] leaf    [LEAVES];
   logic [W-1:0] node_ff [TOTAL];

   // Pad the leaf row up to a full power of the radix.
   for (genvar gi = 0; gi < LEAVES; gi++) begin : g_leaf
      if (gi < N) begin : g_real
         assign leaf[gi] = leaf_in[gi];
      end else begin : g_pad
         assign leaf[gi] = '0;
      end
   end

   // One registered OR node per position of every level.
   for (genvar gk = 1; gk <= LEVELS; gk++) begin : g_level
      localparam int COUNT = TREE_RADIX ** (LEVELS - gk);
      localparam int BASE  = tree_base(LEVELS, gk);
      localparam int CBASE = tree_base(LEVELS, gk - 1);
      for (genvar gj = 0; gj < COUNT; gj++) begin : g_node
         logic [W-1:0] node_in;
         if (gk == 1) begin : g_from_leaf
            always_comb begin
               node_in = '0;
               for (int c = 0; c < TREE_RADIX; c++) begin
                  node_in = node_in | leaf[gj * TREE_RADIX + c];
               end
            end
         end else begin : g_from_node
            always_comb begin
               node_in = '0;
               for (int c = 0; c < TREE_RADIX; c++) begin
                  node_in = node_in | node_ff[CBASE + gj * TREE_RADIX + c];
               end
            end
         end
         always_ff @(posedge clock) begin
            node_ff[BASE + gj] <= node_in;
         end
      end
   end

   assign root_out = node_ff[TOTAL-1];

endmodule

### rtl/bounded_deque_with_insert_core.sv
// ----------------------------------------------------------------------------
// bounded_deque_with_insert_core: ordered deque with positional insert and extract
// A row of CAPACITY cells holds the elements in order; a controller decodes
// each request and broadcasts a shift command to the row.
// ----------------------------------------------------------------------------
// The block takes one request at a time. The cell row applies the action in
// the cycle the request is accepted: every cell loads, shifts from a
// neighbor or holds in parallel. The removed element is then gathered
// through a registered radix-8 OR tree while the controller waits, so
// rsp_valid rises once the tree root holds it, and req_ready returns the
// cycle after the response is taken; a stalled rsp_ready holds off the
// next request. A push or insert onto a full store, a pop or extract on an
// empty store, an insert beyond the count, an extract at or beyond the count
// and an unused action code are answered with rsp_ok low and leave the
// store unchanged. Slots are not cleared at reset; only slots below the
// fill count are read.
// ----------------------------------------------------------------------------
module bounded_deque_with_insert_core
   import bdqi_pkg::*;
#(
   parameter int CAPACITY   = 64,
   parameter int ELEM_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_action,
   input  logic [6:0]  req_position,
   input  logic [31:0] req_element,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_element_out,
   output logic        rsp_ok,
   output logic        rsp_more_left,
   output logic [6:0]  rsp_entry_count
);

   localparam int CW     = $clog2(CAPACITY + 1);
   localparam int PW     = (CW > 7) ? CW : 7;
   localparam int LEVELS = tree_levels(CAPACITY);
   localparam int WCW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;

   state_type       state_ff;
   state_type       state_in;
   logic [WCW-1:0]  wait_ff;
   logic [WCW-1:0]  wait_in;
   logic [CW-1:0]   count_ff;
   logic [CW-1:0]   count_in;
   logic            res_ok_ff;
   logic            res_ok_in;
   logic            res_more_ff;
   logic            res_more_in;
   logic [CW-1:0]   res_count_ff;
   logic [CW-1:0]   res_count_in;

   logic            accept;
   logic            full;
   logic            empty;
   logic [PW-1:0]   pos_x;
   logic [PW-1:0]   count_x;
   logic            ok;
   logic            more;
   logic [CW-1:0]   new_count;
   cell_op_type     op;
   logic            picking;
   logic [CW-1:0]   at;
   logic [CW-1:0]   pick_idx;
   cell_ctrl_type   ctrl;
   logic [ELEM_WIDTH-1:0] elem;
   logic [ELEM_WIDTH-1:0] cell_slot [CAPACITY];
   logic [ELEM_WIDTH-1:0] cell_pick [CAPACITY];
   logic [ELEM_WIDTH-1:0] root;

   assign accept  = req_valid && req_ready;
   assign full    = (count_ff == CW'(CAPACITY));
   assign empty   = (count_ff == '0);
   assign pos_x   = PW'(req_position);
   assign count_x = PW'(count_ff);
   assign elem    = ELEM_WIDTH'(req_element);

   // Decode the request into a cell command and the response fields.
   always_comb begin
      ok        = 1'b0;
      more      = 1'b0;
      new_count = count_ff;
      op        = CELL_HOLD;
      picking   = 1'b0;
      at        = '0;
      pick_idx  = '0;
      case (action_type'(req_action))
         ACT_PUSH_BACK: begin
            ok        = !full;
            op        = CELL_OPEN;
            at        = count_ff;
            new_count = count_ff + CW'(1);
         end
         ACT_POP_BACK: begin
            ok        = !empty;
            picking   = 1'b1;
            pick_idx  = count_ff - CW'(1);
            new_count = count_ff - CW'(1);
            more      = (new_count != '0);
         end
         ACT_PUSH_FRONT: begin
            ok        = !full;
            op        = CELL_OPEN;
            new_count = count_ff + CW'(1);
         end
         ACT_POP_FRONT: begin
            ok        = !empty;
            op        = CELL_CLOSE;
            picking   = 1'b1;
            new_count = count_ff - CW'(1);
            more      = (new_count != '0);
         end
         ACT_INSERT_AT: begin
            ok        = !full && (pos_x <= count_x);
            op        = CELL_OPEN;
            at        = CW'(req_position);
            new_count = count_ff + CW'(1);
         end
         ACT_EXTRACT_AT: begin
            ok        = (pos_x < count_x);
            op        = CELL_CLOSE;
            picking   = 1'b1;
            at        = CW'(req_position);
            pick_idx  = CW'(req_position);
            new_count = count_ff - CW'(1);
         end
         default: begin
            ok = 1'b0;
         end
      endcase
      if (!ok) begin
         more      = 1'b0;
         new_count = count_ff;
         op        = CELL_HOLD;
         picking   = 1'b0;
      end
   end

   // Broadcast command: picks are reloaded on every accepted request.
   always_comb begin
      ctrl.load    = accept;
      ctrl.op      = op;
      ctrl.pick_en = picking;
   end

   // Controller: accept, wait for the readout tree, then present the response.
   always_comb begin
      state_in     = state_ff;
      wait_in      = wait_ff;
      count_in     = count_ff;
      res_ok_in    = res_ok_ff;
      res_more_in  = res_more_ff;
      res_count_in = res_count_ff;
      req_ready    = 1'b0;
      rsp_valid    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               count_in     = new_count;
               res_ok_in    = ok;
               res_more_in  = more;
               res_count_in = new_count;
               wait_in      = WCW'(LEVELS - 1);
               state_in     = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (wait_ff == '0) begin
               state_in = ST_SEND;
            end else begin
               wait_in = wait_ff - WCW'(1);
            end
         end
         ST_SEND: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state with synchronous reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wait_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         wait_ff  <= wait_in;
         count_ff <= count_in;
      end
   end

   // Response fields held until the response is taken.
   always_ff @(posedge clock) begin
      res_ok_ff    <= res_ok_in;
      res_more_ff  <= res_more_in;
      res_count_ff <= res_count_in;
   end

   // The row of cells, each wired to its two neighbors.
   for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic [ELEM_WIDTH-1:0] left_in;
      logic [ELEM_WIDTH-1:0] right_in;
      if (gi == 0) begin : g_first
         assign left_in = '0;
      end else begin : g_left
         assign left_in = cell_slot[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_last
         assign right_in = '0;
      end else begin : g_right
         assign right_in = cell_slot[gi+1];
      end
      bdqi_cell #(
         .W   (ELEM_WIDTH),
         .CW  (CW),
         .IDX (gi)
      ) u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .at       (at),
         .count    (count_ff),
         .pick_idx (pick_idx),
         .elem     (elem),
         .left_in  (left_in),
         .right_in (right_in),
         .slot_out (cell_slot[gi]),
         .pick_out (cell_pick[gi])
      );
   end

   // Gather the removed element from the row.
   bdqi_pick_tree #(
      .N (CAPACITY),
      .W (ELEM_WIDTH)
   ) u_pick_tree (
      .clock    (clock),
      .leaf_in  (cell_pick),
      .root_out (root)
   );

   assign rsp_element_out = 32'(root);
   assign rsp_ok          = res_ok_ff;
   assign rsp_more_left   = res_more_ff;
   assign rsp_entry_count = 7'(res_count_ff);

endmodule

### tb/deque_response_checker.sv
// ----------------------------------------------------------------------------
// deque_response_checker: predicts and checks every response of the deque
// Watches both channels of the bounded deque. Each accepted request is applied
// to a private copy of the ordered store, and the response it should produce
// is queued. Each accepted response is compared field by field with the
// oldest queued one. The mismatch count and the number of responses still
// owed are handed to the testbench top.
// ----------------------------------------------------------------------------
module deque_response_checker
   import bdqi_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [2:0]  req_action,
   input  logic [6:0]  req_position,
   input  logic [31:0] req_element,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_element_out,
   input  logic        rsp_ok,
   input  logic        rsp_more_left,
   input  logic [6:0]  rsp_entry_count,
   output int          mismatches,
   output int          outstanding
);

   // One response as the deque should return it.
   typedef struct packed {
      logic [31:0] element_out;
      logic        ok;
      logic        more_left;
      logic [6:0]  entry_count;
   } deque_rsp_type;

   // Private copy of the ordered store and its fill count.
   logic [31:0] shadow_slots [CAPACITY];
   int          shadow_fill = 0;

   deque_rsp_type owed_responses [$];
   int            mismatch_count = 0;
   int            owed_count = 0;

   assign mismatches  = mismatch_count;
   assign outstanding = owed_count;

   // Print one line for a failed check and count it.
   task automatic report_mismatch(input string what, input logic [31:0] seen,
                                  input logic [31:0] want);
      $display("MISMATCH %s: got %h, expected %h", what, seen, want);
      mismatch_count++;
   endtask

   // Apply one request to the shadow store and return its response.
   function automatic deque_rsp_type apply_action(input logic [2:0] act,
                                                  input logic [6:0] pos,
                                                  input logic [31:0] elem);
      deque_rsp_type rsp;
      int            i;
      logic          full;
      rsp  = '0;
      full = (shadow_fill >= CAPACITY);
      case (act)
         ACT_PUSH_BACK: begin
            if (!full) begin
               shadow_slots[shadow_fill] = elem;
               shadow_fill++;
               rsp.ok = 1'b1;
            end
         end
         ACT_POP_BACK: begin
            if (shadow_fill > 0) begin
               rsp.element_out = shadow_slots[shadow_fill - 1];
               shadow_fill--;
               rsp.ok        = 1'b1;
               rsp.more_left = (shadow_fill > 0);
            end
         end
         ACT_PUSH_FRONT: begin
            if (!full) begin
               for (i = shadow_fill; i > 0; i--) begin
                  shadow_slots[i] = shadow_slots[i - 1];
               end
               shadow_slots[0] = elem;
               shadow_fill++;
               rsp.ok = 1'b1;
            end
         end
         ACT_POP_FRONT: begin
            if (shadow_fill > 0) begin
               rsp.element_out = shadow_slots[0];
               for (i = 0; i + 1 < shadow_fill; i++) begin
                  shadow_slots[i] = shadow_slots[i + 1];
               end
               shadow_fill--;
               rsp.ok        = 1'b1;
               rsp.more_left = (shadow_fill > 0);
            end
         end
         ACT_INSERT_AT: begin
            if (!full && int'(pos) <= shadow_fill) begin
               for (i = shadow_fill; i > int'(pos); i--) begin
                  shadow_slots[i] = shadow_slots[i - 1];
               end
               shadow_slots[pos] = elem;
               shadow_fill++;
               rsp.ok = 1'b1;
            end
         end
         ACT_EXTRACT_AT: begin
            if (int'(pos) < shadow_fill) begin
               rsp.element_out = shadow_slots[pos];
               for (i = int'(pos); i + 1 < shadow_fill; i++) begin
                  shadow_slots[i] = shadow_slots[i + 1];
               end
               shadow_fill--;
               rsp.ok = 1'b1;
            end
         end
         default: begin
            // Spare action codes change nothing and are refused.
         end
      endcase
      rsp.entry_count = shadow_fill[6:0];
      return rsp;
   endfunction

   // Queue a prediction for each accepted request, then check each response.
   always @(posedge clock) begin
      deque_rsp_type want;
      if (reset) begin
         shadow_fill = 0;
         owed_responses.delete();
      end else begin
         if (req_valid && req_ready) begin
            owed_responses.push_back(apply_action(req_action, req_position,
                                                  req_element));
         end
         if (rsp_valid && rsp_ready) begin
            if (owed_responses.size() == 0) begin
               report_mismatch("response with no request owed",
                               32'(rsp_entry_count), 32'(0));
            end else begin
               want = owed_responses.pop_front();
               if (rsp_element_out !== want.element_out) begin
                  report_mismatch("element_out", rsp_element_out, want.element_out);
               end
               if (rsp_ok !== want.ok) begin
                  report_mismatch("ok", 32'(rsp_ok), 32'(want.ok));
               end
               if (rsp_more_left !== want.more_left) begin
                  report_mismatch("more_left", 32'(rsp_more_left), 32'(want.more_left));
               end
               if (rsp_entry_count !== want.entry_count) begin
                  report_mismatch("entry_count", 32'(rsp_entry_count),
                                  32'(want.entry_count));
               end
            end
         end
      end
      owed_count = owed_responses.size();
   end

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the bounded deque with insert
// Drives directed requests over the empty, edge and out-of-range cases, then
// phases of random requests that grow, churn and drain the store under
// varying sender gaps and receiver stalls, including a long response
// hold-off. A checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module testbench;
   import bdqi_pkg::*;

   localparam int          DEPTH      = 64;
   localparam int          LONG_HOLD  = 150;
   localparam logic [2:0]  ACT_SPARE_LO = 3'd6;
   localparam logic [2:0]  ACT_SPARE_HI = 3'd7;

   // Mix of actions used by a random phase.
   typedef enum int {
      MIX_GROW,
      MIX_EVEN,
      MIX_SHRINK
   } action_mix_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_action = '0;
   logic [6:0]  req_position = '0;
   logic [31:0] req_element = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_element_out;
   logic        rsp_ok;
   logic        rsp_more_left;
   logic [6:0]  rsp_entry_count;

   int          mismatches;
   int          outstanding;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          hold_trigger = 0;
   int          hold_seen = 0;
   int          hold_left = 0;

   bounded_deque_with_insert_core #(
      .CAPACITY   (DEPTH),
      .ELEM_WIDTH (32)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_position    (req_position),
      .req_element     (req_element),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_element_out (rsp_element_out),
      .rsp_ok          (rsp_ok),
      .rsp_more_left   (rsp_more_left),
      .rsp_entry_count (rsp_entry_count)
   );

   deque_response_checker #(
      .CAPACITY (DEPTH)
   ) i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_position    (req_position),
      .req_element     (req_element),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_element_out (rsp_element_out),
      .rsp_ok          (rsp_ok),
      .rsp_more_left   (rsp_more_left),
      .rsp_entry_count (rsp_entry_count),
      .mismatches      (mismatches),
      .outstanding     (outstanding)
   );

   // Free-running clock with a period of two units.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Hard stop in case the run hangs.
   initial begin
      #400000;
      $display("CHECKS FAILED");
      $finish;
   end

   // Response side: a long hold-off when triggered, otherwise random stalls.
   always @(negedge clock) begin
      if (hold_trigger != hold_seen) begin
         hold_seen = hold_trigger;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Offer one request after an optional random gap and wait for acceptance.
   // Entered and left at a falling edge; valid stays high on return so that
   // a back-to-back request does not drop it.
   task automatic send_request(input logic [2:0] act, input logic [6:0] pos,
                               input logic [31:0] elem);
      if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid    <= 1'b1;
      req_action   <= act;
      req_position <= pos;
      req_element  <= elem;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Stop offering and wait until every owed response has come back.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
   endtask

   // Pick an action: adds, removes or a spare code, weighted by the mix.
   function automatic logic [2:0] pick_action(input action_mix_type mix);
      int r;
      int add_w;
      r     = $urandom_range(0, 99);
      add_w = (mix == MIX_GROW) ? 78 : (mix == MIX_SHRINK) ? 18 : 48;
      if (r < add_w) begin
         case ($urandom_range(0, 2))
            0:       return ACT_PUSH_BACK;
            1:       return ACT_PUSH_FRONT;
            default: return ACT_INSERT_AT;
         endcase
      end else if (r < 96) begin
         case ($urandom_range(0, 2))
            0:       return ACT_POP_BACK;
            1:       return ACT_POP_FRONT;
            default: return ACT_EXTRACT_AT;
         endcase
      end
      return $urandom_range(0, 1) ? ACT_SPARE_HI : ACT_SPARE_LO;
   endfunction

   // Positions mostly near the front, often anywhere in range, sometimes wild.
   function automatic logic [6:0] pick_position();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) begin
         return 7'($urandom_range(0, 8));
      end else if (r < 80) begin
         return 7'($urandom_range(0, DEPTH));
      end
      return 7'($urandom_range(0, 127));
   endfunction

   // One phase of random requests under the given idling.
   task automatic run_phase(input int count, input int idle_pct, input int stall_pct,
                            input action_mix_type mix);
      int n;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      for (n = 0; n < count; n++) begin
         send_request(pick_action(mix), pick_position(), $urandom());
      end
   endtask

   // Stimulus and verdict.
   initial begin
      int spin;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: removals on an empty store and the spare codes.
      send_request(ACT_POP_BACK,   7'd0,   32'h1111_1111);
      send_request(ACT_POP_FRONT,  7'd0,   32'h2222_2222);
      send_request(ACT_EXTRACT_AT, 7'd0,   32'h3333_3333);
      send_request(ACT_SPARE_LO,   7'd0,   32'hFFFF_FFFF);
      send_request(ACT_SPARE_HI,   7'd127, 32'hFFFF_FFFF);
      // Element extremes at both ends, then inserts at and beyond the count.
      send_request(ACT_PUSH_BACK,  7'd0,   32'h0000_0000);
      send_request(ACT_PUSH_FRONT, 7'd0,   32'hFFFF_FFFF);
      send_request(ACT_INSERT_AT,  7'd2,   32'h1234_5678);
      send_request(ACT_INSERT_AT,  7'd4,   32'hDEAD_BEEF);
      send_request(ACT_INSERT_AT,  7'd127, 32'hCAFE_F00D);
      send_request(ACT_INSERT_AT,  7'd0,   32'hA5A5_A5A5);
      send_request(ACT_INSERT_AT,  7'd1,   32'h5A5A_5A5A);
      // Extracts beyond, in the middle and at the last entry.
      send_request(ACT_EXTRACT_AT, 7'd5,   32'h0);
      send_request(ACT_EXTRACT_AT, 7'd127, 32'h0);
      send_request(ACT_EXTRACT_AT, 7'd2,   32'h0);
      send_request(ACT_EXTRACT_AT, 7'd3,   32'h0);
      // Pops down to empty, with and without entries left behind.
      send_request(ACT_POP_FRONT,  7'd0,   32'h0);
      send_request(ACT_POP_BACK,   7'd0,   32'h0);
      send_request(ACT_POP_FRONT,  7'd0,   32'h0);
      send_request(ACT_POP_BACK,   7'd0,   32'h0);
      wait_for_drain();

      // Random phases: fill to capacity, churn, drain to empty.
      run_phase(100, 0,  0,  MIX_GROW);
      run_phase(100, 61, 0,  MIX_EVEN);
      run_phase(100, 0,  61, MIX_SHRINK);
      wait_for_drain();
      run_phase(100, 23, 23, MIX_GROW);

      // Hold responses off for a long stretch while requests keep coming.
      hold_trigger = hold_trigger + 1;
      run_phase(30, 0, 0, MIX_EVEN);
      wait_for_drain();

      run_phase(100, 0,  0,  MIX_SHRINK);
      run_phase(120, 23, 23, MIX_EVEN);

      // Let every owed response arrive, then let the bench idle before the verdict.
      req_valid <= 1'b0;
      spin = 0;
      while (outstanding != 0 && spin < 5000) begin
         @(negedge clock);
         spin++;
      end
      repeat (10) @(negedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
